// ===== hw/rtl/set_assoc_cache_tag_model_assert.svh =====
// Assertion macros shared by the cache tag model RTL.
// Each macro expands to a concurrent assertion clocked by clk and disabled
// during rst; in synthesis the macros expand to nothing.
`ifndef SET_ASSOC_CACHE_TAG_MODEL_ASSERT_SVH
`define SET_ASSOC_CACHE_TAG_MODEL_ASSERT_SVH
`ifndef SYNTHESIS
// Consequent must hold in the same cycle as the antecedent.
`define CHK_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Consequent must hold in the cycle after the antecedent.
`define CHK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define CHK_SAME(lbl, ante, cons, msg)
`define CHK_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ===== hw/rtl/satc_pkg.sv =====
// Package for the set-associative cache tag model: request and response
// beat types, address and LFSR constants, and the LFSR step function.
// No dependencies.
`default_nettype none

package satc_pkg;

  localparam int ADDR_W = 48;
  localparam int LFSR_W = 32;
  localparam logic [LFSR_W-1:0] LFSR_TAPS = 32'hd000_0001;
  localparam logic [LFSR_W-1:0] LFSR_SEED = 32'h0000_0001;

  typedef struct packed {
    logic [ADDR_W-1:0] virt_addr;
    logic [ADDR_W-1:0] phys_addr;
    logic              is_store;
  } req_t;

  typedef struct packed {
    logic              hit;
    logic              fill_req;
    logic [ADDR_W-1:0] fill_phys_line;
    logic [ADDR_W-1:0] fill_virt_line;
    logic              wb_req;
    logic [ADDR_W-1:0] wb_phys_line;
    logic [ADDR_W-1:0] wb_virt_line;
  } resp_t;

  // One step of the Galois replacement LFSR.
  function automatic logic [LFSR_W-1:0] lfsr_step(input logic [LFSR_W-1:0] r);
    return (r >> 1) ^ (r[0] ? LFSR_TAPS : '0);
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/satc_rem.sv =====
// Remainder of an unsigned value by a constant divisor, one sixteen-bit digit
// at a time by reciprocal multiplication and a correction. A power-of-two
// divisor is a plain mask, ready in the cycle after start. Uses no package.
`default_nettype none

module satc_rem #(
  parameter int WIDTH   = 32,
  parameter int DIVISOR = 4,
  localparam int RW     = (DIVISOR > 1) ? $clog2(DIVISOR) : 1
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [WIDTH-1:0] value,
  output logic                  busy,
  output logic [RW-1:0]         rem
);

  localparam bit POW2   = (DIVISOR & (DIVISOR - 1)) == 0;
  localparam int DIGITS = (WIDTH + 15) / 16;
  localparam int PAD_W  = DIGITS * 16;
  localparam int CNT_W  = $clog2(DIGITS + 1);
  // Reciprocal of the divisor scaled by 2^32. For a 32-bit dividend the
  // quotient estimate it gives is at most one below the true quotient.
  localparam logic [31:0] RECIP = 32'((64'd1 << 32) / 64'(DIVISOR));
  localparam logic [15:0] DIV16 = 16'(DIVISOR);

  logic [PAD_W-1:0] shreg;
  logic [CNT_W-1:0] cnt;
  logic             phase;
  logic [15:0]      part;
  logic [31:0]      step_reg;
  logic [31:0]      q_est;

  logic [31:0]      step_val;
  logic [63:0]      prod;
  logic [31:0]      qd;
  logic [31:0]      diff;
  logic [31:0]      part_next;

  // Horner scheme, most significant digit first: the partial remainder stays
  // below the divisor, so the next dividend fits in 32 bits.
  assign step_val  = {part, shreg[PAD_W-1 -: 16]};
  assign prod      = 64'(step_val) * 64'(RECIP);
  assign qd        = q_est * 32'(DIV16);
  assign diff      = step_reg - qd;
  assign part_next = (diff >= 32'(DIVISOR)) ? diff - 32'(DIVISOR) : diff;

  assign rem = part[RW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      phase <= 1'b0;
      cnt   <= '0;
    end else if (start) begin
      if (POW2) begin
        busy <= 1'b0;
        part <= (DIVISOR == 1) ? '0 : 16'(value[RW-1:0]);
      end else begin
        busy  <= 1'b1;
        phase <= 1'b0;
        cnt   <= CNT_W'(DIGITS);
        shreg <= PAD_W'(value);
        part  <= '0;
      end
    end else if (busy) begin
      if (!phase) begin
        step_reg <= step_val;
        q_est    <= prod[63:32];
        shreg    <= shreg << 16;
        phase    <= 1'b1;
      end else begin
        part  <= part_next[15:0];
        cnt   <= cnt - 1'b1;
        busy  <= (cnt != CNT_W'(1));
        phase <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/set_assoc_cache_tag_model.sv =====
// Top level of the write-back set-associative cache tag model.
// Depends on satc_pkg, satc_rem and set_assoc_cache_tag_model_assert.svh.
//
// This block answers one cache access per request beat with one response
// beat: hit, or a miss with the line-aligned fill addresses and, when the
// randomly chosen victim way was valid and dirty, its writeback addresses.
// Tags and dirty bits live in one synchronous memory with one row per set
// (all ways side by side), and the saved virtual line numbers of the ways
// live in a second memory of the same shape. After reset the block clears
// the tag memory, one set per cycle, and stalls requests meanwhile. It then
// works on one access at a time: the access is taken, its set index
// (physical line modulo NUM_SETS) and the candidate victim way (next LFSR
// value modulo NUM_WAYS) are formed, the set's row is read, and once the
// output is not stalled the row is compared, updated, written back and the
// response registered. With power-of-two NUM_SETS and NUM_WAYS the remainder
// units are plain masks. Otherwise they take their input of W bits a
// sixteen-bit digit at a time through a multiply and then a correction
// step, where W is the line address width (48 - floor(log2(LINE_BYTES)))
// for the set index and 32 for the way, and the access waits until both
// units are done. A new request is taken while a response still waits on a
// stalled output.
`default_nettype none
`include "set_assoc_cache_tag_model_assert.svh"

module set_assoc_cache_tag_model #(
  parameter int NUM_SETS   = 64,
  parameter int NUM_WAYS   = 4,
  parameter int LINE_BYTES = 64
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          req_valid,
  output logic               req_stall,
  input  wire satc_pkg::req_t req,
  output logic               resp_valid,
  input  wire logic          resp_stall,
  output satc_pkg::resp_t    resp
);

  localparam int ADDR_W     = satc_pkg::ADDR_W;
  localparam int LINE_SHIFT = $clog2(LINE_BYTES + 1) - 1;
  localparam int LINE_W     = ADDR_W - LINE_SHIFT;
  localparam int SET_W      = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
  localparam int WAY_W      = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;

  typedef struct packed {
    logic              valid;
    logic              dirty;
    logic [LINE_W-1:0] line;
  } tag_entry_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CALC,
    ST_LOOKUP
  } state_t;

  state_t                        state;
  satc_pkg::req_t                cur;
  logic [satc_pkg::LFSR_W-1:0]   lfsr;
  logic [SET_W-1:0]              clr_idx;

  logic                          start;
  logic                          set_busy;
  logic                          way_busy;
  logic [SET_W-1:0]              set_idx;
  logic [WAY_W-1:0]              way_idx;
  logic                          rd_en;
  logic                          lookup_go;

  // Tag memory and saved virtual line memory, one row per set.
  tag_entry_t [NUM_WAYS-1:0]     tag_mem [NUM_SETS];
  logic [NUM_WAYS-1:0][LINE_W-1:0] virt_mem [NUM_SETS];
  tag_entry_t [NUM_WAYS-1:0]     tag_rd;
  logic [NUM_WAYS-1:0][LINE_W-1:0] virt_rd;

  tag_entry_t [NUM_WAYS-1:0]     tag_wr_row;
  logic [NUM_WAYS-1:0][LINE_W-1:0] virt_wr_row;
  logic                          tag_we;
  logic [SET_W-1:0]              tag_wa;
  tag_entry_t [NUM_WAYS-1:0]     tag_wd;

  logic [LINE_W-1:0]             pline;
  logic [LINE_W-1:0]             vline;
  logic [NUM_WAYS-1:0]           match;
  logic                          hit;
  tag_entry_t                    victim;
  logic [LINE_W-1:0]             victim_vline;
  satc_pkg::resp_t               resp_next;

  assign req_stall = (state != ST_IDLE);
  assign start     = req_valid && !req_stall;

  // The set index comes from the incoming physical line address; the way
  // unit works on the LFSR value that a miss of this access would use.
  satc_rem #(
    .WIDTH   (LINE_W),
    .DIVISOR (NUM_SETS)
  ) u_set_rem (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .value (req.phys_addr[ADDR_W-1:LINE_SHIFT]),
    .busy  (set_busy),
    .rem   (set_idx)
  );

  satc_rem #(
    .WIDTH   (satc_pkg::LFSR_W),
    .DIVISOR (NUM_WAYS)
  ) u_way_rem (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .value (satc_pkg::lfsr_step(lfsr)),
    .busy  (way_busy),
    .rem   (way_idx)
  );

  // Only one access is in flight, and its write-back happens before the
  // next access issues its read, so no forwarding path is needed.
  assign rd_en     = (state == ST_CALC) && !set_busy && !way_busy;
  assign lookup_go = (state == ST_LOOKUP) && (!resp_valid || !resp_stall);

  assign pline = cur.phys_addr[ADDR_W-1:LINE_SHIFT];
  assign vline = cur.virt_addr[ADDR_W-1:LINE_SHIFT];

  always_comb begin
    tag_wr_row  = tag_rd;
    virt_wr_row = virt_rd;
    for (int w = 0; w < NUM_WAYS; w++) begin
      match[w] = tag_rd[w].valid && (tag_rd[w].line == pline);
      if (match[w] && cur.is_store) begin
        tag_wr_row[w].dirty = 1'b1;
      end
    end
    hit          = |match;
    victim       = tag_rd[way_idx];
    victim_vline = virt_rd[way_idx];
    if (!hit) begin
      tag_wr_row[way_idx].valid = 1'b1;
      tag_wr_row[way_idx].dirty = cur.is_store;
      tag_wr_row[way_idx].line  = pline;
      virt_wr_row[way_idx]      = vline;
    end

    resp_next = '0;
    resp_next.hit = hit;
    if (!hit) begin
      resp_next.fill_req       = 1'b1;
      resp_next.fill_phys_line = {pline, {LINE_SHIFT{1'b0}}};
      resp_next.fill_virt_line = {vline, {LINE_SHIFT{1'b0}}};
      if (victim.valid && victim.dirty) begin
        resp_next.wb_req       = 1'b1;
        resp_next.wb_phys_line = {victim.line, {LINE_SHIFT{1'b0}}};
        resp_next.wb_virt_line = {victim_vline, {LINE_SHIFT{1'b0}}};
      end
    end
  end

  // The clearing pass and the lookup write-back share the tag write port.
  assign tag_we = (state == ST_CLEAR) || lookup_go;
  assign tag_wa = (state == ST_CLEAR) ? clr_idx : set_idx;
  assign tag_wd = (state == ST_CLEAR) ? '0 : tag_wr_row;

  always_ff @(posedge clk) begin
    if (tag_we) begin
      tag_mem[tag_wa] <= tag_wd;
    end
    if (rd_en) begin
      tag_rd <= tag_mem[set_idx];
    end
  end

  // Virtual line numbers are only used for a valid victim, which was
  // written when that line was installed, so this memory is never cleared.
  always_ff @(posedge clk) begin
    if (lookup_go && !hit) begin
      virt_mem[set_idx] <= virt_wr_row;
    end
    if (rd_en) begin
      virt_rd <= virt_mem[set_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      clr_idx    <= '0;
      lfsr       <= satc_pkg::LFSR_SEED;
      resp_valid <= 1'b0;
    end else begin
      case (state)
        ST_CLEAR: begin
          clr_idx <= clr_idx + 1'b1;
          if (clr_idx == SET_W'(NUM_SETS - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (req_valid) begin
            cur   <= req;
            state <= ST_CALC;
          end
        end
        ST_CALC: begin
          if (rd_en) begin
            state <= ST_LOOKUP;
          end
        end
        ST_LOOKUP: begin
          if (lookup_go) begin
            resp  <= resp_next;
            state <= ST_IDLE;
            if (!hit) begin
              lfsr <= satc_pkg::lfsr_step(lfsr);
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase

      if (lookup_go) begin
        resp_valid <= 1'b1;
      end else if (!resp_stall) begin
        resp_valid <= 1'b0;
      end
    end
  end

  `CHK_NEXT(a_accept_to_calc, start, state == ST_CALC, "accepted beat did not start a lookup")
  `CHK_SAME(a_no_accept_clear, state == ST_CLEAR, req_stall, "request taken during clear")
  `CHK_SAME(a_single_match, state == ST_LOOKUP, $onehot0(match), "line present in two ways")
  `CHK_NEXT(a_lookup_resp, lookup_go, resp_valid, "finished lookup left no response")
  `CHK_SAME(a_hit_xor_fill, resp_valid, resp.hit != resp.fill_req, "hit and fill disagree")
  `CHK_SAME(a_wb_on_miss, resp_valid && resp.wb_req, resp.fill_req, "writeback without miss")

endmodule

`default_nettype wire
